// ----- rtl/core/slid_pkg.sv -----
package slid_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VALUE_W   = 8;
	localparam int unsigned COUNT_W   = 5;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_DELETE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DELETED  = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic               ins_en;
		logic               del_en;
		logic [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

// ----- rtl/core/slid_cell.sv -----
module slid_cell
	import slid_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               occupied,
	input  logic               left_lt,
	input  logic [VALUE_W-1:0] left_entry,
	input  logic [VALUE_W-1:0] right_entry,
	output logic [VALUE_W-1:0] entry,
	output logic               lt,
	output logic               eq
);

	logic [VALUE_W-1:0] entry_q;

	assign entry = entry_q;
	assign lt    = occupied && (entry_q < ctl.value);
	assign eq    = occupied && (entry_q == ctl.value);

	// On insert the cell that first stops being smaller takes the new value and every
	// later cell takes its left neighbor; on delete every cell from the match onward
	// takes its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !lt) begin
			if (left_lt) begin
				entry_q <= ctl.value;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.del_en && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- rtl/core/sorted_list_insert_delete_unit.sv -----
// Sorted byte table held as a row of DEPTH cells, one value per cell, kept in ascending
// order. An insert word (s_tuser = 0) places s_tdata before the first stored value that
// is not smaller; a delete word (s_tuser = 1) removes the first equal value. Every cell
// compares against the incoming value at once and shifts toward or from its neighbor in
// the same edge, so it takes one word per clock unless an unread result stalls it, and
// returns the result in the next cycle from an output register; it keeps accepting while
// that register drains. Each result carries a status (0 inserted, 1 full, 2 deleted, 3
// not found or empty) and the entry count after the operation, cut to its low five bits.
module sorted_list_insert_delete_unit
	import slid_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // value[7:0]
	input  logic       s_tuser,   // func[0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // status[1:0], count[6:2], zero[7]
);

	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	logic [FILL_W-1:0]  fill_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic               is_insert;
	logic               full;
	logic               found;
	cell_ctl_t          ctl;
	status_t            status_d;
	logic [FILL_W-1:0]  fill_d;
	logic [FILL_W+COUNT_W-1:0] fill_ext;

	logic [VALUE_W-1:0] entry [DEPTH];
	logic [DEPTH-1:0]   lt_vec;
	logic [DEPTH-1:0]   eq_vec;
	logic [DEPTH-1:0]   occ_vec;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign is_insert = (func_t'(s_tuser) == FUNC_INSERT);
	assign full      = (fill_q == FILL_W'(DEPTH));
	assign found     = |eq_vec;

	assign ctl.ins_en = accept && is_insert && !full;
	assign ctl.del_en = accept && !is_insert && found;
	assign ctl.value  = s_tdata;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic               left_lt;
			logic [VALUE_W-1:0] left_entry;
			logic [VALUE_W-1:0] right_entry;

			assign occ_vec[gi] = (FILL_W'(gi) < fill_q);

			if (gi == 0) begin : g_first
				assign left_lt    = 1'b1;
				assign left_entry = s_tdata;
			end else begin : g_mid
				assign left_lt    = lt_vec[gi-1];
				assign left_entry = entry[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign right_entry = entry[gi];
			end else begin : g_inner
				assign right_entry = entry[gi+1];
			end

			slid_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (occ_vec[gi]),
				.left_lt     (left_lt),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (entry[gi]),
				.lt          (lt_vec[gi]),
				.eq          (eq_vec[gi])
			);
		end
	endgenerate

	always_comb begin
		fill_d   = fill_q;
		status_d = ST_NOTFOUND;
		if (is_insert) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				status_d = ST_INSERTED;
				fill_d   = fill_q + FILL_W'(1);
			end
		end else if (found) begin
			status_d = ST_DELETED;
			fill_d   = fill_q - FILL_W'(1);
		end
	end

	assign fill_ext = {{COUNT_W{1'b0}}, fill_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			count_q  <= fill_ext[COUNT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, count_q, status_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_insert && !full) |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("insert did not grow the table");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_insert && !found) |=> $stable(fill_q))
		else $error("failed delete changed the table");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_d == ST_FULL) |-> (fill_q == FILL_W'(DEPTH)))
		else $error("full status with room left");

endmodule
